### design/bracket_balance_checker_unit_assert.svh
`ifndef BRACKET_BALANCE_CHECKER_UNIT_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define BBC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bracket balance checker: same-cycle check failed");

// next-cycle implication, sampled on clock, off during reset
`define BBC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bracket balance checker: next-cycle check failed");

`endif

### design/bbc_pkg.sv
package bbc_pkg;

   localparam int STACK_DEPTH_DEFAULT = 32;

   localparam logic [2:0] KIND_OTHER       = 3'd0;
   localparam logic [2:0] KIND_EMPTY_OPEN  = 3'd1;
   localparam logic [2:0] KIND_EMPTY_CLOSE = 3'd2;
   localparam logic [2:0] KIND_ZERO_OPEN   = 3'd3;
   localparam logic [2:0] KIND_ZERO_CLOSE  = 3'd4;

   localparam logic [1:0] BK_EMPTY_OPEN  = 2'd0;
   localparam logic [1:0] BK_EMPTY_CLOSE = 2'd1;
   localparam logic [1:0] BK_ZERO_OPEN   = 2'd2;
   localparam logic [1:0] BK_ZERO_CLOSE  = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNMATCHED = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] line_no;
      logic [15:0] column_no;
      logic        last_token;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  bracket_kind;
      logic [15:0] bad_line;
      logic [15:0] bad_column;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  bracket_kind;
      logic [15:0] line_no;
      logic [15:0] column_no;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REFILL,
      ST_DUMP_START,
      ST_DUMP
   } state_type;

   typedef struct packed {
      logic accept;
      logic load_top;
      logic rd_first;
      logic emit_single;
      logic emit_entry;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic last_token;
      logic refill_need;
      logic report_single;
      logic last_entry;
      logic slot_free;
   } ctrl_stat_type;

endpackage

### design/bracket_balance_checker_unit.sv
// channel | direction | payload  | handshake
// req     | in        | req_type | req_valid / req_ready
// rsp     | out       | rsp_type | rsp_valid / rsp_ready
//
// A token is taken in the idle state; a matching closer popped from a stack of two
// or more entries then passes the refill state, which reloads the stack-top kind
// from the stack memory. After a last token comes the ok or overflow result, or a
// stack memory read and then one result per remaining entry while a slot is free.
// Reset clears the depth count, overflow flag and output valid; stack memory is not cleared.
// A low rsp_ready holds the report; tokens are taken while a result waits.
`include "bracket_balance_checker_unit_assert.svh"

module bracket_balance_checker_unit import bbc_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type       cmd;
   ctrl_stat_type stat;

   bbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bbc_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   `BBC_ASSERT_NOW(emit_needs_slot, cmd.emit_single || cmd.emit_entry, stat.slot_free)
   `BBC_ASSERT_NOW(no_emit_on_accept, cmd.accept, !(cmd.emit_single || cmd.emit_entry))
   `BBC_ASSERT_NEXT(last_token_blocks, req_valid && req_ready && req_data.last_token, !req_ready)

endmodule

### design/bbc_ctrl.sv
module bbc_ctrl import bbc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ctrl_stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.last_token) begin
                  state_in = ST_DUMP_START;
               end else if (stat.refill_need) begin
                  state_in = ST_REFILL;
               end
            end
         end
         ST_REFILL: begin
            cmd.load_top = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_DUMP_START: begin
            if (stat.report_single) begin
               if (stat.slot_free) begin
                  cmd.emit_single = 1'b1;
                  cmd.clear       = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else begin
               cmd.rd_first = 1'b1;
               state_in     = ST_DUMP;
            end
         end
         ST_DUMP: begin
            if (stat.slot_free) begin
               cmd.emit_entry = 1'b1;
               if (stat.last_entry) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### design/bbc_datapath.sv
module bbc_datapath import bbc_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   output rsp_type       rsp_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  cmd_type       cmd,
   output ctrl_stat_type stat
);

   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   entry_type mem [STACK_DEPTH];

   logic [DW-1:0] depth_ff, depth_in;
   logic          ovf_ff, ovf_in;
   logic [DW-1:0] idx_ff, idx_in;
   logic [1:0]    top_ff, top_in;
   entry_type     rd_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          is_br;
   logic          match;
   logic          do_pop, do_push, do_ovf;
   logic [1:0]    bk;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   entry_type     wr_entry;

   always_comb begin
      is_br = (req_data.kind == KIND_EMPTY_OPEN) || (req_data.kind == KIND_EMPTY_CLOSE) ||
              (req_data.kind == KIND_ZERO_OPEN) || (req_data.kind == KIND_ZERO_CLOSE);
      match = (depth_ff != '0) &&
              (((req_data.kind == KIND_EMPTY_CLOSE) && (top_ff == BK_EMPTY_OPEN)) ||
               ((req_data.kind == KIND_ZERO_CLOSE) && (top_ff == BK_ZERO_OPEN)));
      bk      = 2'(req_data.kind - 3'd1);
      do_pop  = cmd.accept && is_br && !ovf_ff && match;
      do_ovf  = cmd.accept && is_br && !ovf_ff && !match && (depth_ff == DW'(STACK_DEPTH));
      do_push = cmd.accept && is_br && !ovf_ff && !match && (depth_ff != DW'(STACK_DEPTH));

      wr_entry.bracket_kind = bk;
      wr_entry.line_no      = req_data.line_no;
      wr_entry.column_no    = req_data.column_no;

      rd_en   = 1'b0;
      rd_addr = '0;
      if (cmd.rd_first) begin
         rd_en = 1'b1;
      end else if (cmd.emit_entry) begin
         rd_en   = 1'b1;
         rd_addr = AW'(idx_ff + DW'(1));
      end else if (do_pop && (depth_ff >= DW'(2))) begin
         rd_en   = 1'b1;
         rd_addr = AW'(depth_ff - DW'(2));
      end

      depth_in = depth_ff;
      ovf_in   = ovf_ff;
      if (cmd.clear) begin
         depth_in = '0;
         ovf_in   = 1'b0;
      end else if (do_pop) begin
         depth_in = depth_ff - DW'(1);
      end else if (do_push) begin
         depth_in = depth_ff + DW'(1);
      end else if (do_ovf) begin
         ovf_in = 1'b1;
      end

      idx_in = idx_ff;
      if (cmd.rd_first) begin
         idx_in = '0;
      end else if (cmd.emit_entry) begin
         idx_in = idx_ff + DW'(1);
      end

      top_in = top_ff;
      if (do_push) begin
         top_in = bk;
      end else if (cmd.load_top) begin
         top_in = rd_data_ff.bracket_kind;
      end

      stat.last_token    = req_data.last_token;
      stat.refill_need   = is_br && !ovf_ff && match && (depth_ff >= DW'(2));
      stat.report_single = ovf_ff || (depth_ff == '0);
      stat.last_entry    = (idx_ff == depth_ff - DW'(1));
      stat.slot_free     = !rsp_valid_ff || rsp_ready;

      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit_single) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.status       = ovf_ff ? STATUS_OVERFLOW : STATUS_OK;
         rsp_data_in.bracket_kind = '0;
         rsp_data_in.bad_line     = '0;
         rsp_data_in.bad_column   = '0;
         rsp_data_in.last_result  = 1'b1;
      end else if (cmd.emit_entry) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.status       = STATUS_UNMATCHED;
         rsp_data_in.bracket_kind = rd_data_ff.bracket_kind;
         rsp_data_in.bad_line     = rd_data_ff.line_no;
         rsp_data_in.bad_column   = rd_data_ff.column_no;
         rsp_data_in.last_result  = stat.last_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[AW'(depth_ff)] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      top_ff      <= top_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### test/bracket_report_checker.sv
`timescale 1ns / 1ps

module bracket_report_checker import bbc_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_count,
   output int      result_count,
   output int      overflow_count
);

   entry_type   bracket_stack [STACK_DEPTH];
   int unsigned depth;
   logic        overflow_seen;
   rsp_type     report_q [$];

   initial begin
      error_count    = 0;
      pending_count  = 0;
      result_count   = 0;
      overflow_count = 0;
      depth          = 0;
      overflow_seen  = 1'b0;
   end

   task automatic report_mismatch(input string field, input logic [15:0] got,
                                  input logic [15:0] want);
      if (error_count < 40) begin
         $display("[%0t] result %0d: %s got %0h, want %0h", $time, result_count, field,
                  got, want);
      end
      error_count++;
   endtask

   task automatic apply_token(input req_type t);
      logic [1:0] bk;
      bit         is_bracket;
      bit         closes_top;
      rsp_type    r;
      int         i;
      is_bracket = 1'b1;
      bk         = BK_EMPTY_OPEN;
      case (t.kind)
         KIND_EMPTY_OPEN: bk = BK_EMPTY_OPEN;
         KIND_EMPTY_CLOSE: bk = BK_EMPTY_CLOSE;
         KIND_ZERO_OPEN: bk = BK_ZERO_OPEN;
         KIND_ZERO_CLOSE: bk = BK_ZERO_CLOSE;
         default: is_bracket = 1'b0;
      endcase
      if (is_bracket && !overflow_seen) begin
         closes_top = 1'b0;
         if (depth > 0) begin
            closes_top = (t.kind == KIND_EMPTY_CLOSE &&
                          bracket_stack[depth - 1].bracket_kind == BK_EMPTY_OPEN) ||
                         (t.kind == KIND_ZERO_CLOSE &&
                          bracket_stack[depth - 1].bracket_kind == BK_ZERO_OPEN);
         end
         if (closes_top) begin
            depth--;
         end else if (depth >= STACK_DEPTH) begin
            overflow_seen = 1'b1;
         end else begin
            bracket_stack[depth] = '{bracket_kind: bk, line_no: t.line_no,
                                     column_no: t.column_no};
            depth++;
         end
      end
      if (t.last_token) begin
         r             = '0;
         r.last_result = 1'b1;
         if (overflow_seen) begin
            r.status = STATUS_OVERFLOW;
            report_q.insert(report_q.size(), r);
         end else if (depth == 0) begin
            r.status = STATUS_OK;
            report_q.insert(report_q.size(), r);
         end else begin
            for (i = 0; i < depth; i++) begin
               r.status       = STATUS_UNMATCHED;
               r.bracket_kind = bracket_stack[i].bracket_kind;
               r.bad_line     = bracket_stack[i].line_no;
               r.bad_column   = bracket_stack[i].column_no;
               r.last_result  = (i == depth - 1);
               report_q.insert(report_q.size(), r);
            end
         end
         depth         = 0;
         overflow_seen = 1'b0;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         depth         = 0;
         overflow_seen = 1'b0;
         report_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            apply_token(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (report_q.size() == 0) begin
               report_mismatch("result with none pending, status", 16'(rsp_data.status),
                               16'(STATUS_OK));
            end else begin
               want = report_q.pop_front();
               if (rsp_data.status !== want.status) begin
                  report_mismatch("status", 16'(rsp_data.status), 16'(want.status));
               end
               if (rsp_data.bracket_kind !== want.bracket_kind) begin
                  report_mismatch("bracket_kind", 16'(rsp_data.bracket_kind),
                                  16'(want.bracket_kind));
               end
               if (rsp_data.bad_line !== want.bad_line) begin
                  report_mismatch("bad_line", rsp_data.bad_line, want.bad_line);
               end
               if (rsp_data.bad_column !== want.bad_column) begin
                  report_mismatch("bad_column", rsp_data.bad_column, want.bad_column);
               end
               if (rsp_data.last_result !== want.last_result) begin
                  report_mismatch("last_result", 16'(rsp_data.last_result),
                                  16'(want.last_result));
               end
            end
            if (rsp_data.status == STATUS_OVERFLOW) begin
               overflow_count++;
            end
            result_count++;
         end
      end
      pending_count <= report_q.size();
   end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
   import bbc_pkg::*;

   localparam int         STACK_DEPTH   = STACK_DEPTH_DEFAULT;
   localparam int         CYCLE_LIMIT   = 500000;
   localparam int         TARGET_TOKENS = 280;
   localparam int         SETTLE_CYCLES = 2 * STACK_DEPTH + 20;
   localparam logic [2:0] KIND_UNUSED_LAST = 3'd7;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    rsp_ready = 1'b0;
   req_type req_data  = '0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_data;

   int error_count;
   int pending_count;
   int result_count;
   int overflow_count;
   int cycles         = 0;
   int counted_tokens = 0;
   int streams        = 0;
   int full_dumps     = 0;
   bit calm           = 1'b0;

   req_type stream_q [$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   bracket_balance_checker_unit #(
      .STACK_DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   bracket_report_checker #(
      .STACK_DEPTH(STACK_DEPTH)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .error_count(error_count),
      .pending_count(pending_count),
      .result_count(result_count),
      .overflow_count(overflow_count)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[bracket_balance_checker_unit] ERROR");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      if (calm) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end
      if (roll < 88) begin
         return $urandom_range(1, 3);
      end
      if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   initial begin : rsp_pacing
      int stall;
      @(negedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   function automatic logic [15:0] pick_position();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
         return 16'h0000;
      end
      if (roll == 1) begin
         return 16'hFFFF;
      end
      return 16'($urandom);
   endfunction

   function automatic req_type make_token(input logic [2:0] kind, input logic last);
      req_type t;
      t.kind       = kind;
      t.line_no    = pick_position();
      t.column_no  = pick_position();
      t.last_token = last;
      return t;
   endfunction

   function automatic req_type fixed_token(input logic [2:0] kind, input logic [15:0] line_no,
                                           input logic [15:0] column_no, input logic last);
      req_type t;
      t.kind       = kind;
      t.line_no    = line_no;
      t.column_no  = column_no;
      t.last_token = last;
      return t;
   endfunction

   function automatic logic [2:0] other_kind();
      if ($urandom_range(0, 1)) begin
         return KIND_OTHER;
      end
      return 3'($urandom_range(int'(KIND_ZERO_CLOSE) + 1, int'(KIND_UNUSED_LAST)));
   endfunction

   function automatic logic [2:0] bracket_kind_any();
      return 3'($urandom_range(int'(KIND_EMPTY_OPEN), int'(KIND_ZERO_CLOSE)));
   endfunction

   task automatic send_token(input req_type t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      counted_tokens++;
   endtask

   task automatic append_token(input req_type t);
      stream_q.insert(stream_q.size(), t);
   endtask

   task automatic send_stream();
      while (stream_q.size() > 0) begin
         send_token(stream_q.pop_front());
      end
   endtask

   task automatic drain_reports();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic close_stream();
      req_type t;
      if (stream_q.size() > 0 && $urandom_range(0, 1)) begin
         t                             = stream_q[stream_q.size() - 1];
         t.last_token                  = 1'b1;
         stream_q[stream_q.size() - 1] = t;
      end else begin
         append_token(make_token(other_kind(), 1'b1));
      end
   endtask

   task automatic build_balanced();
      logic [2:0] opens [$];
      logic [2:0] k;
      req_type    t;
      int         max_nest;
      int         steps;
      int         i;
      int         idx;
      max_nest = ($urandom_range(0, 9) == 0) ? STACK_DEPTH : $urandom_range(1, 6);
      steps    = (max_nest == STACK_DEPTH) ? 3 * STACK_DEPTH : $urandom_range(1, 14);
      for (i = 0; i < steps; i++) begin
         case ($urandom_range(0, 3))
            0: append_token(make_token(other_kind(), 1'b0));
            1: begin
               if (opens.size() > 0) begin
                  k = opens[opens.size() - 1];
                  opens.delete(opens.size() - 1);
                  append_token(make_token((k == KIND_EMPTY_OPEN) ? KIND_EMPTY_CLOSE :
                                          KIND_ZERO_CLOSE, 1'b0));
               end
            end
            default: begin
               if (opens.size() < max_nest) begin
                  k = $urandom_range(0, 1) ? KIND_EMPTY_OPEN : KIND_ZERO_OPEN;
                  opens.insert(opens.size(), k);
                  append_token(make_token(k, 1'b0));
               end
            end
         endcase
      end
      while (opens.size() > 0) begin
         k = opens[opens.size() - 1];
         opens.delete(opens.size() - 1);
         append_token(make_token((k == KIND_EMPTY_OPEN) ? KIND_EMPTY_CLOSE :
                                 KIND_ZERO_CLOSE, 1'b0));
      end
      if (stream_q.size() > 0 && $urandom_range(0, 4) == 0) begin
         idx           = $urandom_range(0, stream_q.size() - 1);
         t             = stream_q[idx];
         t.kind        = bracket_kind_any();
         stream_q[idx] = t;
      end
      close_stream();
   endtask

   task automatic build_fill(input int pushes);
      logic [2:0] k;
      logic [2:0] top;
      int         i;
      top = KIND_OTHER;
      for (i = 0; i < pushes; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            append_token(make_token(other_kind(), 1'b0));
         end
         k = bracket_kind_any();
         if (k == KIND_EMPTY_CLOSE && top == KIND_EMPTY_OPEN) begin
            k = KIND_EMPTY_OPEN;
         end
         if (k == KIND_ZERO_CLOSE && top == KIND_ZERO_OPEN) begin
            k = KIND_ZERO_OPEN;
         end
         append_token(make_token(k, 1'b0));
         top = k;
      end
      if (pushes > STACK_DEPTH) begin
         repeat ($urandom_range(0, 4)) append_token(make_token(bracket_kind_any(), 1'b0));
      end
      close_stream();
   endtask

   task automatic build_random(input bit brackets_only);
      int n;
      n = $urandom_range(1, 12);
      repeat (n) begin
         append_token(make_token(brackets_only ? bracket_kind_any() :
                                 3'($urandom_range(0, int'(KIND_UNUSED_LAST))),
                                 ($urandom_range(0, 5) == 0)));
      end
      close_stream();
   endtask

   initial begin : stimulus
      int mode;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_token(fixed_token(KIND_OTHER, 16'h0000, 16'h0000, 1'b0));
      send_token(fixed_token(KIND_EMPTY_OPEN, 16'hFFFF, 16'hFFFF, 1'b0));
      send_token(fixed_token(KIND_EMPTY_CLOSE, 16'h0001, 16'h0002, 1'b0));
      send_token(fixed_token(3'(int'(KIND_ZERO_CLOSE) + 1), 16'h1234, 16'h5678, 1'b0));
      send_token(fixed_token(KIND_UNUSED_LAST, 16'hFFFF, 16'hFFFF, 1'b0));
      send_token(fixed_token(KIND_OTHER, 16'hAAAA, 16'h5555, 1'b1));

      send_token(fixed_token(KIND_ZERO_OPEN, 16'h0010, 16'h0001, 1'b0));
      send_token(fixed_token(KIND_EMPTY_CLOSE, 16'h0011, 16'hFFFF, 1'b0));
      send_token(fixed_token(KIND_ZERO_CLOSE, 16'h0012, 16'h0000, 1'b0));
      send_token(fixed_token(KIND_EMPTY_OPEN, 16'h5555, 16'hAAAA, 1'b0));
      send_token(fixed_token(KIND_ZERO_CLOSE, 16'hFFFF, 16'h0003, 1'b0));
      send_token(fixed_token(3'(int'(KIND_ZERO_CLOSE) + 2), 16'h0000, 16'h0000, 1'b1));

      send_token(fixed_token(KIND_ZERO_OPEN, 16'h8000, 16'h7FFF, 1'b1));
      send_token(fixed_token(KIND_ZERO_CLOSE, 16'h7FFF, 16'h8000, 1'b1));

      send_token(fixed_token(KIND_EMPTY_OPEN, 16'h0020, 16'h0001, 1'b0));
      send_token(fixed_token(KIND_EMPTY_OPEN, 16'h0020, 16'h0002, 1'b0));
      send_token(fixed_token(KIND_ZERO_OPEN, 16'h0020, 16'h0003, 1'b0));
      send_token(fixed_token(KIND_ZERO_CLOSE, 16'h0020, 16'h0004, 1'b0));
      send_token(fixed_token(KIND_EMPTY_CLOSE, 16'h0020, 16'h0005, 1'b0));
      send_token(fixed_token(KIND_EMPTY_CLOSE, 16'h0020, 16'h0006, 1'b1));
      drain_reports();

      while (counted_tokens < TARGET_TOKENS) begin
         calm = ($urandom_range(0, 3) == 0);
         mode = (streams == 0) ? 0 : (streams == 1) ? 1 : $urandom_range(0, 19);
         case (mode)
            0: begin
               build_fill(STACK_DEPTH);
               full_dumps++;
            end
            1: build_fill(STACK_DEPTH + $urandom_range(1, 3));
            2, 3: build_random(1'b0);
            4, 5, 6, 7: build_random(1'b1);
            default: build_balanced();
         endcase
         send_stream();
         if (streams == 2 || $urandom_range(0, 4) == 0) begin
            drain_reports();
         end
         streams++;
      end

      calm = 1'b0;
      drain_reports();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("run covered %0d tokens in total, %0d random streams after the directed set",
               counted_tokens, streams);
      $display("%0d results checked, %0d overflow reports, %0d full-stack dumps",
               result_count, overflow_count, full_dumps);
      if (error_count == 0 && pending_count == 0) begin
         $display("[bracket_balance_checker_unit] OK");
      end else begin
         $display("[bracket_balance_checker_unit] ERROR");
      end
      $finish;
   end

endmodule
